// ===== src/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Shared types and constants for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  // byte store depth, a power of two so that a position is its low bits
  localparam int BUFFER_DEPTH = 16;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  // byte index and count must also hold the depth itself
  localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);
  localparam int LEN_W        = 5;
  localparam int POS_W        = 4;

  // direction bit appended to the address byte
  localparam logic DIR_WRITE = 1'b0;
  localparam logic DIR_READ  = 1'b1;

  // error codes
  localparam logic ERR_NONE = 1'b0;
  localparam logic ERR_NACK = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_EVENT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TX   = 2'd1,
    PH_RX   = 2'd2
  } phase_t;

endpackage

// ===== src/i2c_master_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Steps an interrupt-driven I2C master transfer: start, byte send, receive
// with dummy read and NACK before the last byte, STOP and error on NACK.
// ----------------------------------------------------------------------------
// Every item gives exactly one result item. Items are taken at one per clock
// while the result register is not stalled: an item is held in the input
// register, then the sequencer state and the byte store update as its result
// is loaded into the result register. The next item sees the state that the
// previous one left, since that update is a single pass of logic in the step
// from input register to result register.
// A full result register stalls the input register, which then stalls the
// input channel; the store has no reset and an entry must be loaded or
// received before it is sent.
module i2c_master_transfer_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [6:0] target_address,
  input  logic [i2cmts_pkg::LEN_W-1:0] transfer_length,
  input  logic [i2cmts_pkg::POS_W-1:0] load_position,
  input  logic [7:0] load_value,
  input  logic       ack_missing,
  input  logic [7:0] bus_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       drive_valid,
  output logic [7:0] drive_byte,
  output logic       master_on,
  output logic       transmit_dir,
  output logic       nack_next,
  output logic       dummy_read,
  output logic       rx_valid,
  output logic [7:0] rx_byte,
  output logic [i2cmts_pkg::POS_W-1:0] rx_position,
  output logic       busy_res,
  output logic       error_code
);
  import i2cmts_pkg::*;

  // input register
  logic                s1_valid;
  mode_t               s1_mode;
  logic [6:0]          s1_addr;
  logic [LEN_W-1:0]    s1_len;
  logic [POS_W-1:0]    s1_lpos;
  logic [7:0]          s1_lval;
  logic                s1_nak;
  logic [7:0]          s1_bbyte;

  logic advance;

  // sequencer state
  phase_t              phase, phase_next;
  logic                address_pending, address_pending_next;
  logic [COUNT_W-1:0]  byte_index, byte_index_next;
  logic [COUNT_W-1:0]  byte_count, byte_count_next;
  logic [7:0]          byte_store [BUFFER_DEPTH];

  // store write port and read data
  logic                store_we;
  logic [IDX_W-1:0]    store_waddr;
  logic [7:0]          store_wdata;
  logic [7:0]          store_rdata;

  // result of the current step
  logic                r_dv, r_dummy, r_rv, r_err, r_on, r_dir, r_nn;
  logic [7:0]          r_db, r_rb;
  logic [POS_W-1:0]    r_rp;
  logic [COUNT_W-1:0]  len_clamped;
  logic [COUNT_W:0]    index_plus_one;
  logic [COUNT_W:0]    index_next_plus_one;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode  <= mode_t'(mode);
      s1_addr  <= target_address;
      s1_len   <= transfer_length;
      s1_lpos  <= load_position;
      s1_lval  <= load_value;
      s1_nak   <= ack_missing;
      s1_bbyte <= bus_byte;
    end
  end

  // store read at the current byte index
  assign store_rdata = byte_store[byte_index[IDX_W-1:0]];

  // length clamped to one..depth
  always_comb begin
    if (s1_len == '0) begin
      len_clamped = COUNT_W'(1);
    end else if (32'(s1_len) > BUFFER_DEPTH) begin
      len_clamped = COUNT_W'(BUFFER_DEPTH);
    end else begin
      len_clamped = COUNT_W'(s1_len);
    end
  end

  assign index_plus_one = {1'b0, byte_index} + (COUNT_W+1)'(1);

  // next state and step result
  always_comb begin
    phase_next           = phase;
    address_pending_next = address_pending;
    byte_index_next      = byte_index;
    byte_count_next      = byte_count;
    store_we             = 1'b0;
    store_waddr          = s1_lpos[IDX_W-1:0];
    store_wdata          = s1_lval;
    r_dv                 = 1'b0;
    r_db                 = '0;
    r_dummy              = 1'b0;
    r_rv                 = 1'b0;
    r_rb                 = '0;
    r_rp                 = '0;
    r_err                = ERR_NONE;
    if (advance) begin
      unique case (s1_mode)
        MODE_LOAD: begin
          store_we = 1'b1;
        end
        MODE_WRITE, MODE_READ: begin
          if (phase == PH_IDLE) begin
            byte_count_next      = len_clamped;
            byte_index_next      = '0;
            address_pending_next = 1'b1;
            phase_next           = (s1_mode == MODE_WRITE) ? PH_TX : PH_RX;
            r_dv                 = 1'b1;
            r_db = {s1_addr, (s1_mode == MODE_READ) ? DIR_READ : DIR_WRITE};
          end
        end
        MODE_EVENT: begin
          unique case (phase)
            PH_TX: begin
              address_pending_next = 1'b0;
              if (s1_nak) begin
                phase_next = PH_IDLE;
                r_err      = ERR_NACK;
              end else if (byte_index >= byte_count) begin
                phase_next = PH_IDLE;
              end else begin
                r_dv            = 1'b1;
                r_db            = store_rdata;
                byte_index_next = index_plus_one[COUNT_W-1:0];
              end
            end
            PH_RX: begin
              if (address_pending) begin
                address_pending_next = 1'b0;
                if (s1_nak) begin
                  phase_next = PH_IDLE;
                  r_err      = ERR_NACK;
                end else begin
                  byte_index_next = '0;
                  r_dummy         = 1'b1;
                end
              end else begin
                store_we    = 1'b1;
                store_waddr = byte_index[IDX_W-1:0];
                store_wdata = s1_bbyte;
                r_rv        = 1'b1;
                r_rb        = s1_bbyte;
                r_rp        = POS_W'(byte_index[IDX_W-1:0]);
                if (index_plus_one >= {1'b0, byte_count}) begin
                  phase_next = PH_IDLE;
                end
                byte_index_next = index_plus_one[COUNT_W-1:0];
              end
            end
            default: begin
              // event while idle is ignored
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // status after the step
  assign index_next_plus_one = {1'b0, byte_index_next} + (COUNT_W+1)'(1);

  always_comb begin
    r_on = (phase_next != PH_IDLE);
    unique case (phase_next)
      PH_TX:   r_dir = 1'b1;
      PH_RX:   r_dir = address_pending_next;
      default: r_dir = 1'b0;
    endcase
    r_nn = (phase_next == PH_RX) && !address_pending_next &&
           ({1'b0, byte_count_next} <= index_next_plus_one);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      address_pending <= 1'b0;
      byte_index      <= '0;
      byte_count      <= '0;
    end else begin
      phase           <= phase_next;
      address_pending <= address_pending_next;
      byte_index      <= byte_index_next;
      byte_count      <= byte_count_next;
    end
  end

  // byte store
  always_ff @(posedge clk) begin
    if (store_we) begin
      byte_store[store_waddr] <= store_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_valid  <= r_dv;
      drive_byte   <= r_db;
      master_on    <= r_on;
      transmit_dir <= r_dir;
      nack_next    <= r_nn;
      dummy_read   <= r_dummy;
      rx_valid     <= r_rv;
      rx_byte      <= r_rb;
      rx_position  <= r_rp;
      busy_res     <= r_on;
      error_code   <= r_err;
    end
  end

  // a running transfer always has a length in range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (byte_count != '0 && 32'(byte_count) <= BUFFER_DEPTH))
    else $error("byte count out of range during transfer");

  // the index never runs past the length
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (byte_index <= byte_count))
    else $error("byte index beyond byte count");

  // a result never both sends and receives a byte
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_valid && rx_valid))
    else $error("result sends and receives at once");

  // a nack error always releases the bus
  a_err_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == ERR_NACK) |-> (!master_on && !drive_valid))
    else $error("error result keeps the bus");

  // stalled results do not let the state move
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(phase) && $stable(byte_index))
    else $error("state changed while result stalled");

endmodule
